// ===== hdl/ljf_pkg.sv =====
// Shared types, microprogram and IEEE single-precision helpers for the
// Lennard-Jones force accumulator. No dependencies.
package ljf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] TwelveBits = 32'h4140_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROBE_POS = 2'd0,
    REG_MIN_DIST  = 2'd1,
    REG_WELL_DEPTH = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    UNIT_MUL,
    UNIT_ADD,
    UNIT_SUB,
    UNIT_DIV
  } unit_e;

  typedef enum logic [3:0] {
    SRC_X0,
    SRC_RM,
    SRC_EPS,
    SRC_POS,
    SRC_TWELVE,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_SUM
  } src_e;

  typedef enum logic [2:0] {
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3,
    DST_SUM
  } dst_e;

  typedef struct packed {
    logic  start;
    unit_e unit;
    src_e  src_a;
    src_e  src_b;
    dst_e  dst;
    logic  emit;
  } ljf_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
    logic last;
  } ljf_stat_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] val;
  } fp_spec_t;

  localparam logic [3:0] LastStep = 4'd11;

  // One operation per step; the temporaries are reused as values die.
  function automatic ljf_cmd_t ljf_prog(input logic [3:0] step);
    ljf_cmd_t c;
    c = '{start: 1'b1, unit: UNIT_MUL, src_a: SRC_RM, src_b: SRC_RM, dst: DST_T0,
          emit: 1'b0};
    unique case (step)
      4'd0:  begin c.unit = UNIT_MUL; c.src_a = SRC_RM;     c.src_b = SRC_RM;  c.dst = DST_T0; end
      4'd1:  begin c.unit = UNIT_SUB; c.src_a = SRC_X0;     c.src_b = SRC_POS; c.dst = DST_T1; end
      4'd2:  begin c.unit = UNIT_MUL; c.src_a = SRC_T1;     c.src_b = SRC_T1;  c.dst = DST_T2; end
      4'd3:  begin c.unit = UNIT_DIV; c.src_a = SRC_T0;     c.src_b = SRC_T2;  c.dst = DST_T0; end
      4'd4:  begin c.unit = UNIT_MUL; c.src_a = SRC_T0;     c.src_b = SRC_T0;  c.dst = DST_T2; end
      4'd5:  begin c.unit = UNIT_MUL; c.src_a = SRC_T2;     c.src_b = SRC_T0;  c.dst = DST_T2; end
      4'd6:  begin c.unit = UNIT_MUL; c.src_a = SRC_T2;     c.src_b = SRC_T2;  c.dst = DST_T3; end
      4'd7:  begin c.unit = UNIT_SUB; c.src_a = SRC_T3;     c.src_b = SRC_T2;  c.dst = DST_T3; end
      4'd8:  begin c.unit = UNIT_MUL; c.src_a = SRC_TWELVE; c.src_b = SRC_EPS; c.dst = DST_T0; end
      4'd9:  begin c.unit = UNIT_MUL; c.src_a = SRC_T0;     c.src_b = SRC_T3;  c.dst = DST_T3; end
      4'd10: begin c.unit = UNIT_DIV; c.src_a = SRC_T3;     c.src_b = SRC_T1;  c.dst = DST_T3; end
      4'd11: begin c.unit = UNIT_ADD; c.src_a = SRC_SUM;    c.src_b = SRC_T3;  c.dst = DST_SUM; end
      default: begin c.unit = UNIT_ADD; c.src_a = SRC_SUM;  c.src_b = SRC_T3;  c.dst = DST_SUM; end
    endcase
    return c;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != '0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == '0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] x);
    return x[30:0] == '0;
  endfunction

  function automatic logic [23:0] fp_man(input logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  // Subnormals share the exponent of the smallest normal.
  function automatic logic [7:0] fp_exp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
  endfunction

  // m: leading one at bit 26, bits 2..0 guard and sticky; e: biased exponent
  // of that leading one. Rounds to nearest even, gradual underflow.
  function automatic logic [31:0] fp_round_pack(input logic s,
                                                input logic signed [11:0] e,
                                                input logic [26:0] m);
    logic [26:0] mm;
    logic [11:0] shw;
    logic        lost;
    logic        inc;
    logic [30:0] pk;
    mm = m;
    shw = '0;
    lost = 1'b0;
    if (m == '0) begin
      return {s, 31'd0};
    end
    if (e >= 12'sd255) begin
      return {s, 8'hFF, 23'd0};
    end
    if (e <= 12'sd0) begin
      shw = 12'(12'sd1 - e);
      if (shw > 12'd27) begin
        mm = {26'd0, |m};
      end else begin
        lost = |(m & ((27'd1 << shw) - 27'd1));
        mm = m >> shw;
        mm[0] = mm[0] | lost;
      end
      pk = {8'd0, mm[25:3]};
    end else begin
      pk = {e[7:0], mm[25:3]};
    end
    inc = mm[2] & (mm[1] | mm[0] | mm[3]);
    pk = pk + 31'(inc);
    return {s, pk};
  endfunction

  function automatic fp_spec_t fp_mul_special(input logic [31:0] a, input logic [31:0] b);
    fp_spec_t r;
    logic     s;
    s = a[31] ^ b[31];
    r.hit = 1'b1;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_zero(b)) ||
        (fp_is_zero(a) && fp_is_inf(b))) begin
      r.val = QnanBits;
    end else if (fp_is_inf(a) || fp_is_inf(b)) begin
      r.val = {s, 8'hFF, 23'd0};
    end else if (fp_is_zero(a) || fp_is_zero(b)) begin
      r.val = {s, 31'd0};
    end else begin
      r.hit = 1'b0;
      r.val = '0;
    end
    return r;
  endfunction

  function automatic fp_spec_t fp_div_special(input logic [31:0] a, input logic [31:0] b);
    fp_spec_t r;
    logic     s;
    s = a[31] ^ b[31];
    r.hit = 1'b1;
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_zero(a) && fp_is_zero(b)) ||
        (fp_is_inf(a) && fp_is_inf(b))) begin
      r.val = QnanBits;
    end else if (fp_is_inf(a) || fp_is_zero(b)) begin
      r.val = {s, 8'hFF, 23'd0};
    end else if (fp_is_zero(a) || fp_is_inf(b)) begin
      r.val = {s, 31'd0};
    end else begin
      r.hit = 1'b0;
      r.val = '0;
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  d;
    logic [26:0] xm;
    logic [26:0] ym;
    logic [26:0] ys;
    logic        lost;
    logic [27:0] sum;
    logic [27:0] n;
    logic [5:0]  lz;
    logic signed [11:0] e;
    if (fp_is_nan(a) || fp_is_nan(b) ||
        (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]))) begin
      return QnanBits;
    end
    if (fp_is_inf(a)) begin
      return a;
    end
    if (fp_is_inf(b)) begin
      return b;
    end
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    d = fp_exp(x) - fp_exp(y);
    xm = {fp_man(x), 3'd0};
    ym = {fp_man(y), 3'd0};
    if (d >= 8'd27) begin
      ys = {26'd0, |ym};
    end else begin
      lost = |(ym & ((27'd1 << d) - 27'd1));
      ys = ym >> d;
      ys[0] = ys[0] | lost;
    end
    if (x[31] == y[31]) begin
      sum = {1'b0, xm} + {1'b0, ys};
    end else begin
      sum = {1'b0, xm} - {1'b0, ys};
    end
    if (sum == '0) begin
      return {x[31] & y[31], 31'd0};
    end
    lz = lzc48({sum, 20'd0});
    n = sum << lz;
    e = $signed({4'd0, fp_exp(x)}) + 12'sd1 - $signed({6'd0, lz});
    return fp_round_pack(x[31], e, {n[27:2], |n[1:0]});
  endfunction

endpackage

// ===== hdl/ljf_fdiv.sv =====
// Restoring divider for IEEE single, one quotient bit per cycle.
// Depends on ljf_pkg.
module ljf_fdiv import ljf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  localparam logic [4:0] QuotBits = 5'd27;

  logic [5:0]         lza;
  logic [5:0]         lzb;
  logic [23:0]        man_a;
  logic [23:0]        man_b;
  logic signed [11:0] e0;
  fp_spec_t           spec;

  logic               busy_q;
  logic               done_q;
  logic [4:0]         cnt_q;
  logic [24:0]        rem_q;
  logic [23:0]        dsr_q;
  logic [26:0]        quo_q;
  logic signed [11:0] exp_q;
  logic               sgn_q;
  fp_spec_t           spec_q;
  logic [31:0]        res_q;

  logic               ge;
  logic [24:0]        rem_sub;
  logic               sticky;
  logic [31:0]        packed_res;

  assign lza   = lzc48({fp_man(a_i), 24'd0});
  assign lzb   = lzc48({fp_man(b_i), 24'd0});
  assign man_a = 24'(fp_man(a_i) << lza);
  assign man_b = 24'(fp_man(b_i) << lzb);
  assign e0    = $signed({4'd0, fp_exp(a_i)}) - $signed({6'd0, lza})
               - $signed({4'd0, fp_exp(b_i)}) + $signed({6'd0, lzb}) + 12'sd126;
  assign spec  = fp_div_special(a_i, b_i);

  assign ge      = rem_q >= {1'b0, dsr_q};
  assign rem_sub = ge ? (rem_q - {1'b0, dsr_q}) : rem_q;
  assign sticky  = rem_q != '0;

  always_comb begin
    if (quo_q[26]) begin
      packed_res = fp_round_pack(sgn_q, exp_q + 12'sd1, {quo_q[26:1], quo_q[0] | sticky});
    end else begin
      packed_res = fp_round_pack(sgn_q, exp_q, {quo_q[25:0], sticky});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QuotBits;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, man_a};
      dsr_q  <= man_b;
      quo_q  <= '0;
      exp_q  <= e0;
      sgn_q  <= a_i[31] ^ b_i[31];
      spec_q <= spec;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        quo_q <= {quo_q[25:0], ge};
        rem_q <= {rem_sub[23:0], 1'b0};
      end else begin
        res_q <= spec_q.hit ? spec_q.val : packed_res;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hdl/ljf_dp.sv =====
// Datapath: configuration registers, temporaries, float multiply and add,
// the divider and the output register. Depends on ljf_pkg and ljf_fdiv.
module ljf_dp import ljf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         in_load_i,
  input  logic [31:0]  in_pos_i,
  input  logic         in_last_i,
  input  ljf_cmd_t     cmd_i,
  output ljf_stat_t    stat_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [31:0]  out_data_o
);

  logic [31:0] x0_q, rm_q, eps_q;
  logic [31:0] pos_q;
  logic        last_q;
  logic [31:0] t0_q, t1_q, t2_q, t3_q, sum_q;
  dst_e        dst_q;
  logic [31:0] out_q;
  logic        out_valid_q;

  logic [31:0] opa, opb;

  logic               mul_v_q;
  logic [47:0]        mul_prod_q;
  logic signed [11:0] mul_e_q;
  logic               mul_s_q;
  fp_spec_t           mul_sp_q;
  logic [5:0]         mul_lz;
  logic [47:0]        mul_n;
  logic [31:0]        mul_res;

  logic        add_v_q;
  logic [31:0] add_a_q, add_b_q;
  logic [31:0] add_res;

  logic        div_done;
  logic [31:0] div_res;
  logic        done;
  logic [31:0] wb_val;

  function automatic logic [31:0] pick(input src_e s, input logic [31:0] x0,
                                       input logic [31:0] rm, input logic [31:0] eps,
                                       input logic [31:0] pos, input logic [31:0] t0,
                                       input logic [31:0] t1, input logic [31:0] t2,
                                       input logic [31:0] t3, input logic [31:0] sum);
    logic [31:0] v;
    unique case (s)
      SRC_X0:     v = x0;
      SRC_RM:     v = rm;
      SRC_EPS:    v = eps;
      SRC_POS:    v = pos;
      SRC_TWELVE: v = TwelveBits;
      SRC_T0:     v = t0;
      SRC_T1:     v = t1;
      SRC_T2:     v = t2;
      SRC_T3:     v = t3;
      SRC_SUM:    v = sum;
      default:    v = sum;
    endcase
    return v;
  endfunction

  assign opa = pick(cmd_i.src_a, x0_q, rm_q, eps_q, pos_q, t0_q, t1_q, t2_q, t3_q, sum_q);
  assign opb = pick(cmd_i.src_b, x0_q, rm_q, eps_q, pos_q, t0_q, t1_q, t2_q, t3_q, sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q  <= '0;
      rm_q  <= '0;
      eps_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROBE_POS:  x0_q  <= cfg_data_i;
        REG_MIN_DIST:   rm_q  <= cfg_data_i;
        REG_WELL_DEPTH: eps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiply: product registered, normalise and round in the next cycle.
  always_ff @(posedge clk_i) begin
    mul_prod_q <= fp_man(opa) * fp_man(opb);
    mul_e_q    <= $signed({4'd0, fp_exp(opa)}) + $signed({4'd0, fp_exp(opb)});
    mul_s_q    <= opa[31] ^ opb[31];
    mul_sp_q   <= fp_mul_special(opa, opb);
    add_a_q    <= opa;
    add_b_q    <= (cmd_i.unit == UNIT_SUB) ? {~opb[31], opb[30:0]} : opb;
  end

  assign mul_lz  = lzc48(mul_prod_q);
  assign mul_n   = mul_prod_q << mul_lz;
  assign mul_res = mul_sp_q.hit ? mul_sp_q.val :
                   fp_round_pack(mul_s_q, mul_e_q - 12'sd126 - $signed({6'd0, mul_lz}),
                                 {mul_n[47:22], |mul_n[21:0]});
  assign add_res = fp_add(add_a_q, add_b_q);

  ljf_fdiv u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && (cmd_i.unit == UNIT_DIV)),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign done   = mul_v_q | add_v_q | div_done;
  assign wb_val = mul_v_q ? mul_res : (add_v_q ? add_res : div_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q     <= 1'b0;
      add_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      dst_q       <= DST_T0;
    end else begin
      mul_v_q <= cmd_i.start && (cmd_i.unit == UNIT_MUL);
      add_v_q <= cmd_i.start && ((cmd_i.unit == UNIT_ADD) || (cmd_i.unit == UNIT_SUB));
      if (cmd_i.start) begin
        dst_q <= cmd_i.dst;
      end
      if (done && (dst_q == DST_SUM)) begin
        sum_q <= wb_val;
      end
      // Emit the total and clear the running sum.
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        sum_q       <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      pos_q  <= in_pos_i;
      last_q <= in_last_i;
    end
    if (done) begin
      unique case (dst_q)
        DST_T0:  t0_q <= wb_val;
        DST_T1:  t1_q <= wb_val;
        DST_T2:  t2_q <= wb_val;
        DST_T3:  t3_q <= wb_val;
        DST_SUM: ;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_q <= fp_is_nan(sum_q) ? QnanBits : sum_q;
    end
  end

  assign stat_o.done     = done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.last     = last_q;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== hdl/ljf_ctrl.sv =====
// Controller: steps through the per-particle operation list and hands the
// total to the output register. Depends on ljf_pkg.
module ljf_ctrl import ljf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ljf_stat_t stat_i,
  output ljf_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [3:0] step_q;
  ljf_cmd_t   cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cmd_q   <= '{start: 1'b0, unit: UNIT_MUL, src_a: SRC_RM, src_b: SRC_RM,
                   dst: DST_T0, emit: 1'b0};
    end else begin
      cmd_q.start <= 1'b0;
      cmd_q.emit  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= ljf_prog(4'd0);
            step_q  <= 4'd0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (stat_i.done) begin
            if (step_q == LastStep) begin
              if (!stat_i.last) begin
                state_q <= ST_IDLE;
              end else if (stat_i.out_free) begin
                cmd_q.emit <= 1'b1;
                state_q    <= ST_IDLE;
              end else begin
                state_q <= ST_EMIT;
              end
            end else begin
              cmd_q  <= ljf_prog(step_q + 4'd1);
              step_q <= step_q + 4'd1;
            end
          end
        end
        ST_EMIT: begin
          // Hold until the previous total has left.
          if (stat_i.out_free) begin
            cmd_q.emit <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd_q;

endmodule

// ===== hdl/lj_force_accumulate_1d.sv =====
// Top level of the Lennard-Jones force accumulator (one dimension, single).
// Depends on ljf_pkg, ljf_ctrl, ljf_dp.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid_i/tready_o     tdata: particle_pos; tlast: is_last
//   m_axis    out        m_axis_tvalid_o/tready_i     tdata: total_force
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One particle runs ten multiply or add steps and two divisions on the bit-serial
// divider (27 quotient bits, then rounding and the handover), and the block takes
// the next beat only once it is idle again. Only a beat marked tlast gives a total:
// the final add writes the running sum, and the emit command copies it to the
// output register. The next particle is taken while that beat waits, unless an
// older total still waits, in which case hold the input until it has left.
// Reset clears the configuration registers and the running sum to zero; cfg is always ready.
module lj_force_accumulate_1d import ljf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [DataW-1:0]   s_axis_tdata_i,   // [31:0] particle_pos
  input  logic               s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [DataW-1:0]   m_axis_tdata_o,   // [31:0] total_force
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  ljf_cmd_t  cmd;
  ljf_stat_t stat;
  logic      in_ready;

  ljf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ljf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_load_i   (s_axis_tvalid_i && in_ready),
    .in_pos_i    (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

  assign s_axis_tready_o = in_ready;
  assign cfg_ready_o     = 1'b1;

endmodule

// ===== hdl/ljf_checker.sv =====
// Port-level checks for lj_force_accumulate_1d, attached by bind.
// Depends on ljf_pkg.
module ljf_checker import ljf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [DataW-1:0]   s_axis_tdata_i,
  input logic               s_axis_tlast_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [DataW-1:0]   m_axis_tdata_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [DataW-1:0]   cfg_data_i
);

  // A particle beat occupies the block: no second beat in the next cycle.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken on consecutive cycles");

  // A waiting total holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed while stalled");

  // A presented total carries known bits.
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !$isunknown(m_axis_tdata_o))
    else $error("output beat carries unknown bits");

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i |-> !$isunknown({s_axis_tdata_i, s_axis_tlast_i}))
    else $error("input beat carries unknown bits");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o && (!cfg_valid_i || !$isunknown({cfg_index_i, cfg_data_i})))
    else $error("configuration port not ready or write unknown");

endmodule

bind lj_force_accumulate_1d ljf_checker u_ljf_checker (.*);
